@@ sv/countdown_timer_bank_core_macros.svh @@
// ----------------------------------------------------------------------------
// countdown timer bank: assertion macros
// Shared concurrent assertion forms, clocked on clock, for the checker.
// ----------------------------------------------------------------------------
`ifndef COUNTDOWN_TIMER_BANK_CORE_MACROS_SVH
`define COUNTDOWN_TIMER_BANK_CORE_MACROS_SVH

// checked outside reset only
`define CTB_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// also checked while reset is high
`define CTB_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ sv/ctb_pkg.sv @@
// ----------------------------------------------------------------------------
// ctb_pkg
// Types and fixed field widths for the countdown timer bank.
// ----------------------------------------------------------------------------
`default_nettype none

package ctb_pkg;

   localparam int KIND_W    = 2;
   localparam int ID_W      = 4;
   localparam int SECS_IN_W = 16;
   localparam int SLOT_W    = 4;

   typedef enum logic [KIND_W-1:0] {
      KIND_SET   = 2'd0,
      KIND_UNSET = 2'd1,
      KIND_TICK  = 2'd2
   } kind_type;

   localparam logic EVT_START = 1'b0;
   localparam logic EVT_STOP  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic scan_en;
   } ctb_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic pend_valid;
      logic scan_done;
   } ctb_sts_type;

endpackage

`default_nettype wire

@@ sv/ctb_ram.sv @@
// ----------------------------------------------------------------------------
// ctb_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ctb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

@@ sv/ctb_ctrl.sv @@
// ----------------------------------------------------------------------------
// ctb_ctrl
// Controller: takes requests when idle and runs the tick scan to its end.
// ----------------------------------------------------------------------------
`default_nettype none

module ctb_ctrl
   import ctb_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic [KIND_W-1:0] req_kind,
   output logic                   req_ready,
   output ctb_cmd_type            cmd,
   input  wire ctb_sts_type       sts
);

   state_type state_ff, state_in;

   always_comb begin
      req_ready   = (state_ff == ST_IDLE) && !sts.pend_valid;
      cmd.accept  = req_valid && req_ready;
      cmd.scan_en = (state_ff == ST_SCAN);
      state_in    = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.accept && (req_kind == KIND_TICK)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.scan_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/ctb_dpath.sv @@
// ----------------------------------------------------------------------------
// ctb_dpath
// Datapath: active flags, count RAM, slot scanner, pending event and output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module ctb_dpath
   import ctb_pkg::*;
#(
   parameter int NUM_TIMERS    = 16,
   parameter int SECONDS_WIDTH = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ctb_cmd_type          cmd,
   output ctb_sts_type               sts,
   input  wire logic [KIND_W-1:0]    req_kind,
   input  wire logic [ID_W-1:0]      req_timer_id,
   input  wire logic [SECS_IN_W-1:0] req_seconds,
   input  wire logic                 rsp_ready,
   output logic                      rsp_valid,
   output logic                      rsp_event_res,
   output logic      [SLOT_W-1:0]    rsp_slot,
   output logic                      rsp_last
);

   localparam int IDX_W = $clog2(NUM_TIMERS);

   logic [NUM_TIMERS-1:0]    active_ff, active_in;
   logic [IDX_W-1:0]         rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]         chk_idx_ff, chk_idx_in;
   logic                     chk_vld_ff, chk_vld_in;
   logic                     pend_valid_ff, pend_valid_in;
   logic                     pend_evt_ff, pend_evt_in;
   logic [SLOT_W-1:0]        pend_slot_ff, pend_slot_in;
   logic                     pend_final_ff, pend_final_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_evt_ff, rsp_evt_in;
   logic [SLOT_W-1:0]        rsp_slot_ff, rsp_slot_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                     ram_we;
   logic [IDX_W-1:0]         ram_waddr;
   logic [SECONDS_WIDTH-1:0] ram_wdata;
   logic [IDX_W-1:0]         ram_raddr;
   logic [SECONDS_WIDTH-1:0] ram_rdata;

   logic                     id_ok;
   logic [IDX_W-1:0]         id_idx;
   logic                     id_act;
   logic [SECONDS_WIDTH-1:0] secs;
   logic                     chk_act;
   logic                     chk_last;
   logic                     expire;
   logic                     out_take;
   logic                     advance;
   logic                     move_out;

   ctb_ram #(
      .WIDTH (SECONDS_WIDTH),
      .DEPTH (NUM_TIMERS)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      id_ok    = int'(req_timer_id) < NUM_TIMERS;
      id_idx   = IDX_W'(req_timer_id);
      id_act   = id_ok && active_ff[id_idx];
      secs     = SECONDS_WIDTH'(req_seconds);
      chk_act  = chk_vld_ff && active_ff[chk_idx_ff];
      chk_last = (chk_idx_ff == IDX_W'(NUM_TIMERS - 1));
      // counts of zero and one both run out on this tick
      expire   = chk_act && (ram_rdata < SECONDS_WIDTH'(2));
      out_take = !rsp_valid_ff || rsp_ready;
      // a second expiry stalls the scan until the held event can move out
      advance  = cmd.scan_en && !(expire && pend_valid_ff && !out_take);
      move_out = pend_valid_ff && out_take && (pend_final_ff || (advance && expire));
      // on a stall the checked slot is read again so the read data stays put
      ram_raddr = advance ? rd_idx_ff : chk_idx_ff;

      sts.pend_valid = pend_valid_ff;
      sts.scan_done  = advance && chk_vld_ff && chk_last;

      active_in     = active_ff;
      rd_idx_in     = rd_idx_ff;
      chk_idx_in    = chk_idx_ff;
      chk_vld_in    = chk_vld_ff;
      pend_valid_in = pend_valid_ff;
      pend_evt_in   = pend_evt_ff;
      pend_slot_in  = pend_slot_ff;
      pend_final_in = pend_final_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_evt_in    = rsp_evt_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_last_in   = rsp_last_ff;
      ram_we        = 1'b0;
      ram_waddr     = chk_idx_ff;
      ram_wdata     = ram_rdata - SECONDS_WIDTH'(1);

      // output register
      if (move_out) begin
         rsp_valid_in  = 1'b1;
         rsp_evt_in    = pend_evt_ff;
         rsp_slot_in   = pend_slot_ff;
         rsp_last_in   = pend_final_ff;
         pend_valid_in = 1'b0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // set and unset finish in the accepting cycle
      if (cmd.accept && (req_kind == KIND_SET) && id_ok) begin
         ram_we    = 1'b1;
         ram_waddr = id_idx;
         ram_wdata = secs;
         if (!id_act) begin
            active_in[id_idx] = 1'b1;
            pend_valid_in     = 1'b1;
            pend_evt_in       = EVT_START;
            pend_slot_in      = req_timer_id;
            pend_final_in     = 1'b1;
         end
      end
      if (cmd.accept && (req_kind == KIND_UNSET) && id_act) begin
         active_in[id_idx] = 1'b0;
         pend_valid_in     = 1'b1;
         pend_evt_in       = EVT_STOP;
         pend_slot_in      = req_timer_id;
         pend_final_in     = 1'b1;
      end
      if (cmd.accept && (req_kind == KIND_TICK)) begin
         rd_idx_in  = '0;
         chk_vld_in = 1'b0;
      end

      // tick scan, one slot per cycle while the scan is not stalled
      if (advance) begin
         chk_vld_in = 1'b1;
         chk_idx_in = rd_idx_ff;
         rd_idx_in  = rd_idx_ff + IDX_W'(1);
         if (chk_act) begin
            if (expire) begin
               active_in[chk_idx_ff] = 1'b0;
               pend_valid_in         = 1'b1;
               pend_evt_in           = EVT_STOP;
               pend_slot_in          = SLOT_W'(chk_idx_ff);
               pend_final_in         = chk_last;
            end else begin
               ram_we = 1'b1;
            end
         end
         if (chk_vld_ff && chk_last) begin
            chk_vld_in = 1'b0;
            if (!expire && pend_valid_ff) begin
               pend_final_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= '0;
         chk_vld_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         active_ff     <= active_in;
         chk_vld_ff    <= chk_vld_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      chk_idx_ff    <= chk_idx_in;
      pend_evt_ff   <= pend_evt_in;
      pend_slot_ff  <= pend_slot_in;
      pend_final_ff <= pend_final_in;
      rsp_evt_ff    <= rsp_evt_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_event_res = rsp_evt_ff;
   assign rsp_slot      = rsp_slot_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

`default_nettype wire

@@ sv/countdown_timer_bank_core.sv @@
// ----------------------------------------------------------------------------
// countdown_timer_bank_core
// Bank of numbered countdown timers with start and stop events.
//
//   channel  direction  fields                              handshake
//   req      in         req_kind, req_timer_id, req_seconds req_valid/req_ready
//   rsp      out        rsp_event_res, rsp_slot, rsp_last   rsp_valid/rsp_ready
//
// set and unset are done in the cycle they are taken; their event goes via the
// pending event register, then the output register, to rsp. a tick keeps
// req_ready low while it scans: slot 0 is read, then one slot per cycle except while the scan waits on rsp.
// requests wait while an event is still held ahead of the output register.
// synchronous reset clears the active flags at once; counts need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module countdown_timer_bank_core
   import ctb_pkg::*;
#(
   parameter int NUM_TIMERS    = 16,
   parameter int SECONDS_WIDTH = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [KIND_W-1:0]    req_kind,
   input  wire logic [ID_W-1:0]      req_timer_id,
   input  wire logic [SECS_IN_W-1:0] req_seconds,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_event_res,
   output logic      [SLOT_W-1:0]    rsp_slot,
   output logic                      rsp_last
);

   ctb_cmd_type cmd;
   ctb_sts_type sts;

   ctb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_ready (req_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   ctb_dpath #(
      .NUM_TIMERS    (NUM_TIMERS),
      .SECONDS_WIDTH (SECONDS_WIDTH)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_kind      (req_kind),
      .req_timer_id  (req_timer_id),
      .req_seconds   (req_seconds),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .rsp_event_res (rsp_event_res),
      .rsp_slot      (rsp_slot),
      .rsp_last      (rsp_last)
   );

endmodule

`default_nettype wire

@@ sv/ctb_checker.sv @@
// ----------------------------------------------------------------------------
// ctb_checker
// Port level checks for the countdown timer bank, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "countdown_timer_bank_core_macros.svh"

module ctb_checker
   import ctb_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic [KIND_W-1:0] req_kind,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic              rsp_event_res,
   input wire logic [SLOT_W-1:0] rsp_slot,
   input wire logic              rsp_last
);

   // a start transaction is always the only one its request causes
   `CTB_ASSERT(a_start_is_last, rsp_valid && (rsp_event_res == EVT_START) |-> rsp_last, "start event not marked last")

   // a tick occupies the scanner, so nothing new is taken next cycle
   `CTB_ASSERT(a_tick_blocks, req_valid && req_ready && (req_kind == KIND_TICK) |=> !req_ready, "request taken during tick scan")

   `CTB_ASSERT_RST(a_reset_quiet, reset |=> !rsp_valid, "response valid right after reset")

   `CTB_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_slot) && $stable(rsp_event_res) && $stable(rsp_last), "stalled response changed")

endmodule

bind countdown_timer_bank_core ctb_checker u_ctb_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_kind      (req_kind),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_event_res (rsp_event_res),
   .rsp_slot      (rsp_slot),
   .rsp_last      (rsp_last)
);

`default_nettype wire

@@ test/countdown_timer_bank_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// countdown_timer_bank_core_tb
// Sends set, unset, tick and unused-kind transactions into the timer bank.
// A built-in model of the slot counts and active flags predicts start and
// stop events, and some directed rows give theirs from the table. All are
// checked in order on the rsp channel, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------

module countdown_timer_bank_core_tb;
   import ctb_pkg::*;

   localparam int NUM_TIMERS    = 16;
   localparam int SECONDS_WIDTH = 16;
   localparam int RANDOM_ITEMS  = 260;
   localparam int STALL_LIMIT   = 1000;
   localparam int DRAIN_CYCLES  = NUM_TIMERS + 8;
   localparam int SIDE_REQ      = 0;
   localparam int SIDE_RSP      = 1;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   typedef struct packed {
      logic              evt;
      logic [SLOT_W-1:0] slot;
      logic              last;
   } timer_event_type;

   // how a directed row gets its expected events
   typedef enum logic [1:0] {
      ROW_PREDICT,
      ROW_SILENT,
      ROW_ONE
   } row_check_type;

   typedef struct packed {
      logic [KIND_W-1:0]    kind;
      logic [ID_W-1:0]      id;
      logic [SECS_IN_W-1:0] secs;
      row_check_type        check;
      logic                 evt;
      logic [SLOT_W-1:0]    slot;
   } stim_row_type;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [KIND_W-1:0]    req_kind = KIND_TICK;
   logic [ID_W-1:0]      req_timer_id = '0;
   logic [SECS_IN_W-1:0] req_seconds = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_event_res;
   logic [SLOT_W-1:0]    rsp_slot;
   logic                 rsp_last;

   // model of the timer bank
   logic [SECONDS_WIDTH-1:0] count_left [NUM_TIMERS];
   logic [NUM_TIMERS-1:0]    running;
   timer_event_type          expected_events[$];

   int errors;
   int items_sent;
   int events_seen;
   int starts_seen;
   int stops_seen;
   int widest_tick;
   int run_left [2];
   bit calm [2];

   // slot 0 gets a zero count, the others alternate 0 and 1, so the
   // tick at the end of the table expires every slot at once
   stim_row_type dir_tbl [24] = '{
      '{KIND_TICK,   4'd0,  16'h0000, ROW_SILENT,  EVT_START, 4'd0},
      '{KIND_UNSET,  4'd3,  16'h0000, ROW_SILENT,  EVT_START, 4'd0},
      '{KIND_UNUSED, 4'd9,  16'hffff, ROW_SILENT,  EVT_START, 4'd0},
      '{KIND_SET,    4'd0,  16'h0000, ROW_ONE,     EVT_START, 4'd0},
      '{KIND_SET,    4'd15, 16'hffff, ROW_ONE,     EVT_START, 4'd15},
      '{KIND_SET,    4'd15, 16'h0002, ROW_SILENT,  EVT_START, 4'd0},
      '{KIND_UNSET,  4'd15, 16'h0000, ROW_ONE,     EVT_STOP,  4'd15},
      '{KIND_SET,    4'd15, 16'h0001, ROW_ONE,     EVT_START, 4'd15},
      '{KIND_SET,    4'd1,  16'h0000, ROW_ONE,     EVT_START, 4'd1},
      '{KIND_SET,    4'd2,  16'h0001, ROW_ONE,     EVT_START, 4'd2},
      '{KIND_SET,    4'd3,  16'h0000, ROW_ONE,     EVT_START, 4'd3},
      '{KIND_SET,    4'd4,  16'h0001, ROW_ONE,     EVT_START, 4'd4},
      '{KIND_SET,    4'd5,  16'h0000, ROW_ONE,     EVT_START, 4'd5},
      '{KIND_SET,    4'd6,  16'h0001, ROW_ONE,     EVT_START, 4'd6},
      '{KIND_SET,    4'd7,  16'h0000, ROW_ONE,     EVT_START, 4'd7},
      '{KIND_SET,    4'd8,  16'h0001, ROW_ONE,     EVT_START, 4'd8},
      '{KIND_SET,    4'd9,  16'h0000, ROW_ONE,     EVT_START, 4'd9},
      '{KIND_SET,    4'd10, 16'h0001, ROW_ONE,     EVT_START, 4'd10},
      '{KIND_SET,    4'd11, 16'h0000, ROW_ONE,     EVT_START, 4'd11},
      '{KIND_SET,    4'd12, 16'h0001, ROW_ONE,     EVT_START, 4'd12},
      '{KIND_SET,    4'd13, 16'h0000, ROW_ONE,     EVT_START, 4'd13},
      '{KIND_SET,    4'd14, 16'h0001, ROW_ONE,     EVT_START, 4'd14},
      '{KIND_TICK,   4'd0,  16'h0000, ROW_PREDICT, EVT_START, 4'd0},
      '{KIND_UNSET,  4'd0,  16'h0000, ROW_SILENT,  EVT_START, 4'd0}
   };

   countdown_timer_bank_core #(
      .NUM_TIMERS    (NUM_TIMERS),
      .SECONDS_WIDTH (SECONDS_WIDTH)
   ) u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_timer_id  (req_timer_id),
      .req_seconds   (req_seconds),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_event_res (rsp_event_res),
      .rsp_slot      (rsp_slot),
      .rsp_last      (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // runs of busy or calm transactions, so both gaps and back-to-back traffic occur
   function automatic int draw_wait(int side);
      if (run_left[side] == 0) begin
         run_left[side] = int'($urandom_range(5, 30));
         calm[side] = ($urandom_range(0, 2) == 0);
      end
      run_left[side]--;
      return calm[side] ? 0 : int'($urandom_range(0, 5));
   endfunction

   task automatic step_timer_model(input logic [KIND_W-1:0] kind,
                                   input logic [ID_W-1:0] id,
                                   input logic [SECS_IN_W-1:0] secs,
                                   input bit record);
      timer_event_type evs[$];
      case (kind)
         KIND_SET: begin
            if (id < NUM_TIMERS) begin
               count_left[id] = secs[SECONDS_WIDTH-1:0];
               if (!running[id]) begin
                  running[id] = 1'b1;
                  evs.push_back('{EVT_START, id, 1'b1});
               end
            end
         end
         KIND_UNSET: begin
            if (id < NUM_TIMERS && running[id]) begin
               running[id] = 1'b0;
               count_left[id] = '0;
               evs.push_back('{EVT_STOP, id, 1'b1});
            end
         end
         KIND_TICK: begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
               if (running[i]) begin
                  if (count_left[i] <= 1) begin
                     count_left[i] = '0;
                     running[i] = 1'b0;
                     evs.push_back('{EVT_STOP, SLOT_W'(i), 1'b0});
                  end else begin
                     count_left[i] = count_left[i] - 1'b1;
                  end
               end
            end
            if (evs.size() > 0) evs[evs.size()-1].last = 1'b1;
            if (evs.size() > widest_tick) widest_tick = evs.size();
         end
         default: ;
      endcase
      if (record) foreach (evs[k]) expected_events.push_back(evs[k]);
   endtask

   task automatic send_item(input logic [KIND_W-1:0] kind,
                            input logic [ID_W-1:0] id,
                            input logic [SECS_IN_W-1:0] secs);
      int gap;
      gap = draw_wait(SIDE_REQ);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_timer_id <= id;
      req_seconds  <= secs;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic report_field(input string field, input int want, input int got);
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
   endtask

   // stimulus and end of run
   initial begin
      int pick;
      int effective;
      int s;
      logic [KIND_W-1:0]    kind;
      logic [ID_W-1:0]      id;
      logic [SECS_IN_W-1:0] secs;
      bit                   useful;

      effective = 0;
      running = '0;
      foreach (count_left[i]) count_left[i] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tbl[r]) begin
         send_item(dir_tbl[r].kind, dir_tbl[r].id, dir_tbl[r].secs);
         step_timer_model(dir_tbl[r].kind, dir_tbl[r].id, dir_tbl[r].secs,
                          dir_tbl[r].check == ROW_PREDICT);
         if (dir_tbl[r].check == ROW_ONE)
            expected_events.push_back('{dir_tbl[r].evt, dir_tbl[r].slot, 1'b1});
      end

      // mostly short counts so expiries keep coming; unsets favor live slots
      while (effective < RANDOM_ITEMS) begin
         pick = int'($urandom_range(0, 99));
         id = ID_W'($urandom_range(0, NUM_TIMERS - 1));
         secs = SECS_IN_W'($urandom);
         if (pick < 40) begin
            kind = KIND_SET;
            s = int'($urandom_range(0, 19));
            if (s < 16) secs = SECS_IN_W'($urandom_range(0, 6));
            else if (s == 18) secs = '0;
            else if (s == 19) secs = '1;
         end else if (pick < 55) begin
            kind = KIND_UNSET;
            if (running != '0 && $urandom_range(0, 3) != 0)
               do id = ID_W'($urandom_range(0, NUM_TIMERS - 1)); while (!running[id]);
         end else if (pick < 94) begin
            kind = KIND_TICK;
         end else begin
            kind = KIND_UNUSED;
         end
         useful = (kind == KIND_SET) || (kind == KIND_TICK) ||
                  (kind == KIND_UNSET && running[id]);
         send_item(kind, id, secs);
         step_timer_model(kind, id, secs, 1'b1);
         if (useful) effective++;
      end
      req_valid <= 1'b0;

      while (expected_events.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d request transactions, %0d events checked (%0d start, %0d stop)",
               items_sent, events_seen, starts_seen, stops_seen);
      $display("most expiries from a single tick: %0d, mismatches: %0d", widest_tick, errors);
      if (errors == 0) begin
         $display("countdown_timer_bank_core_tb: PASS");
      end else begin
         $display("countdown_timer_bank_core_tb: FAIL");
      end
      $finish;
   end

   // event receiver and checker
   initial begin
      int stall;
      timer_event_type want;
      timer_event_type got;

      while (reset) @(posedge clock);
      forever begin
         stall = draw_wait(SIDE_RSP);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got = '{rsp_event_res, rsp_slot, rsp_last};
         events_seen++;
         if (got.evt == EVT_START) starts_seen++;
         else stops_seen++;
         if (expected_events.size() == 0) begin
            errors++;
            $display("%0t: unexpected event: expected none, actual event_res %0d slot %0d last %0d",
                     $time, got.evt, got.slot, got.last);
         end else begin
            want = expected_events.pop_front();
            if (got.evt !== want.evt) report_field("event_res", want.evt, got.evt);
            if (got.slot !== want.slot) report_field("slot", want.slot, got.slot);
            if (got.last !== want.last) report_field("last", want.last, got.last);
         end
      end
   end

   // watchdog on cycles with no transaction on either channel
   initial begin
      int quiet;
      quiet = 0;
      while (reset) @(posedge clock);
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("%0t: no transaction for %0d cycles, %0d events still expected",
               $time, STALL_LIMIT, expected_events.size());
      $display("countdown_timer_bank_core_tb: FAIL");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+sv
sv/ctb_pkg.sv
sv/ctb_ram.sv
sv/ctb_ctrl.sv
sv/ctb_dpath.sv
sv/countdown_timer_bank_core.sv
sv/ctb_checker.sv
test/countdown_timer_bank_core_tb.sv
